// ----- rtl/bounded_ordered_list_unit_defines.svh -----
// assertion macros for the bounded ordered list unit
`ifndef BOUNDED_ORDERED_LIST_UNIT_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define BOL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BOL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BOL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define BOL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/bol_pkg.sv -----
package bol_pkg;

    localparam int CAPACITY    = 16;
    localparam int MAX_RESULTS = 16;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int POS_W  = 8;
    localparam int STAT_W = 2;
    localparam int ELEM_W = 4;
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int VIEW_MAX = (CAPACITY > MAX_RESULTS) ? CAPACITY : MAX_RESULTS;
    localparam int VIEW_W = $clog2(VIEW_MAX + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT   = 3'd0,
        CMD_PUSH_BACK    = 3'd1,
        CMD_POP_FRONT    = 3'd2,
        CMD_POP_BACK     = 3'd3,
        CMD_INSERT_AFTER = 3'd4,
        CMD_DELETE_AT    = 3'd5,
        CMD_VIEW         = 3'd6
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_NOPOS = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_ROTATE = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] value_in;
        logic [POS_W-1:0]         position;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic [STAT_W-1:0]        status;
        logic [ELEM_W-1:0]        elem_pos;
        logic                     last;
    } t_rsp;

    typedef struct packed {
        t_cell_op                 op;
        logic [IDX_W-1:0]         idx;
        logic [IDX_W-1:0]         last_idx;
        logic signed [DATA_W-1:0] data;
    } t_cell_ctrl;

endpackage

// ----- rtl/bol_cell.sv -----
module bol_cell (
    input  logic                              i_clk,
    input  logic [bol_pkg::IDX_W-1:0]         i_index,
    input  bol_pkg::t_cell_ctrl               i_ctrl,
    input  logic signed [bol_pkg::DATA_W-1:0] i_left,
    input  logic signed [bol_pkg::DATA_W-1:0] i_right,
    output logic signed [bol_pkg::DATA_W-1:0] o_value
);
    import bol_pkg::*;

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            OP_INSERT: begin
                if (i_index == i_ctrl.idx) begin
                    n_value = i_ctrl.data;
                end else if (i_index > i_ctrl.idx) begin
                    n_value = i_left;
                end
            end
            OP_REMOVE: begin
                if (i_index >= i_ctrl.idx) begin
                    n_value = i_right;
                end
            end
            OP_ROTATE: begin
                if (i_index == i_ctrl.last_idx) begin
                    n_value = i_ctrl.data;
                end else begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ----- rtl/bounded_ordered_list_unit.sv -----
// bounded ordered list unit
// keeps an ordered list of signed 32-bit values in a chain of cells, one cell per
// position; every change shifts the cells at or beyond the touched position by one
// request channel: i_req_valid / o_req_stall with payload i_req (cmd, value_in,
// position); response channel: o_rsp_valid / i_rsp_stall with payload o_rsp
// (value_out, status, elem_pos, last)
// push, pop, insert and delete give one response in the cycle after the request is
// taken; a new request is taken every cycle while the response register drains
// view rotates the chain one cell per cycle unless a stalled response holds it,
// giving one response per element (at most 16) with last on the final one; the
// first passes through the state register and then the response register; no
// request is taken until the rotation is done
// code 7 is taken and dropped without a response
// a stalled response holds in the output register; a view simply pauses its
// rotation, and the request side stalls until the response register frees up
// reset (synchronous, active low) empties the list; cell contents are not cleared,
// since no position at or beyond the count is ever read
`include "bounded_ordered_list_unit_defines.svh"

module bounded_ordered_list_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  bol_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output bol_pkg::t_rsp o_rsp
);
    import bol_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_VIEW = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [VIEW_W-1:0]  r_view, n_view;
    logic               r_rsp_valid, n_rsp_valid;
    t_rsp               r_rsp, n_rsp;

    t_cell_ctrl               ctrl;
    logic signed [DATA_W-1:0] cell_q [CAPACITY];
    logic [IDX_W-1:0]         rd_idx;
    logic                     slot_free;
    logic                     req_acc;
    logic                     pos_bad;
    logic                     full;
    logic                     empty;
    logic [VIEW_W-1:0]        count_v;
    logic [VIEW_W-1:0]        view_n;
    logic [VIEW_W-1:0]        view_nxt;
    logic                     emit;
    logic                     rsp_load;
    t_rsp                     rsp_new;

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] left_v;
        logic signed [DATA_W-1:0] right_v;
        if (g == 0) begin : g_first
            assign left_v = '0;
        end else begin : g_mid_l
            assign left_v = cell_q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_v = cell_q[g];
        end else begin : g_mid_r
            assign right_v = cell_q[g+1];
        end
        bol_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_ctrl  (ctrl),
            .i_left  (left_v),
            .i_right (right_v),
            .o_value (cell_q[g])
        );
    end

    assign slot_free   = !r_rsp_valid || !i_rsp_stall;
    assign o_req_stall = !((r_state == S_IDLE) && slot_free);
    assign req_acc     = i_req_valid && !o_req_stall;
    assign pos_bad     = i_req.position >= POS_W'(r_count);
    assign full        = r_count == CNT_W'(CAPACITY);
    assign empty       = r_count == '0;
    assign count_v     = VIEW_W'(r_count);
    assign view_n      = (count_v < VIEW_W'(MAX_RESULTS)) ? count_v : VIEW_W'(MAX_RESULTS);
    assign view_nxt    = r_view + VIEW_W'(1);
    assign emit        = r_view < view_n;

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_view        = r_view;
        n_rsp_valid   = r_rsp_valid && i_rsp_stall;
        n_rsp         = r_rsp;
        ctrl.op       = OP_HOLD;
        ctrl.idx      = '0;
        ctrl.last_idx = IDX_W'(r_count - CNT_W'(1));
        ctrl.data     = i_req.value_in;
        rd_idx        = '0;
        rsp_load      = 1'b0;
        rsp_new       = '0;
        rsp_new.last  = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    case (t_cmd'(i_req.cmd))
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            rsp_load = 1'b1;
                            if (full) begin
                                rsp_new.status = ST_FULL;
                            end else begin
                                ctrl.op  = OP_INSERT;
                                ctrl.idx = (t_cmd'(i_req.cmd) == CMD_PUSH_FRONT) ?
                                           '0 : IDX_W'(r_count);
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK: begin
                            rsp_load = 1'b1;
                            if (empty) begin
                                rsp_new.status = ST_EMPTY;
                            end else begin
                                rd_idx = (t_cmd'(i_req.cmd) == CMD_POP_FRONT) ?
                                         '0 : IDX_W'(r_count - CNT_W'(1));
                                rsp_new.value_out = cell_q[rd_idx];
                                ctrl.op  = OP_REMOVE;
                                ctrl.idx = rd_idx;
                                n_count  = r_count - CNT_W'(1);
                            end
                        end
                        CMD_INSERT_AFTER: begin
                            rsp_load = 1'b1;
                            if (pos_bad) begin
                                rsp_new.status = ST_NOPOS;
                            end else if (full) begin
                                rsp_new.status = ST_FULL;
                            end else begin
                                ctrl.op  = OP_INSERT;
                                ctrl.idx = IDX_W'(i_req.position) + IDX_W'(1);
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        CMD_DELETE_AT: begin
                            rsp_load = 1'b1;
                            if (pos_bad) begin
                                rsp_new.status = ST_NOPOS;
                            end else begin
                                rd_idx = IDX_W'(i_req.position);
                                rsp_new.value_out = cell_q[rd_idx];
                                ctrl.op  = OP_REMOVE;
                                ctrl.idx = rd_idx;
                                n_count  = r_count - CNT_W'(1);
                            end
                        end
                        CMD_VIEW: begin
                            if (empty) begin
                                rsp_load       = 1'b1;
                                rsp_new.status = ST_EMPTY;
                            end else begin
                                n_state = S_VIEW;
                                n_view  = '0;
                            end
                        end
                        default: begin
                            rsp_load = 1'b0;
                        end
                    endcase
                end
            end
            S_VIEW: begin
                // rotate left by one; head goes to the tail of the live list
                if (!emit || slot_free) begin
                    ctrl.op   = OP_ROTATE;
                    ctrl.data = cell_q[0];
                    n_view    = view_nxt;
                    if (emit) begin
                        rsp_load          = 1'b1;
                        rsp_new.value_out = cell_q[0];
                        rsp_new.status    = ST_OK;
                        rsp_new.elem_pos  = r_view[ELEM_W-1:0];
                        rsp_new.last      = view_nxt == view_n;
                    end
                    if (view_nxt == count_v) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (rsp_load) begin
            n_rsp_valid = 1'b1;
            n_rsp       = rsp_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_view <= n_view;
        r_rsp  <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    `BOL_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(CAPACITY), "count beyond capacity")
    `BOL_ASSERT_IMPL(a_view_range, i_clk, i_rst_n, r_state == S_VIEW,
        r_view < count_v, "view index past count")
    `BOL_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, 1'b1,
        (r_count == $past(r_count)) || (r_count == $past(r_count) + CNT_W'(1)) ||
        (r_count == $past(r_count) - CNT_W'(1)), "count jumped")

endmodule

// ----- sim/bounded_ordered_list_unit_tb.sv -----
module bounded_ordered_list_unit_tb;
    import bol_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 90;

    class list_scoreboard;
        logic signed [DATA_W-1:0] elems[$];
        t_rsp expected_q[$];
        int unsigned errors = 0;

        function int unsigned fill();
            return elems.size();
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void add_expected(logic signed [DATA_W-1:0] val, t_status st,
                                   logic [ELEM_W-1:0] pos, logic fin);
            t_rsp rsp;
            rsp.value_out = val;
            rsp.status    = st;
            rsp.elem_pos  = pos;
            rsp.last      = fin;
            expected_q.push_back(rsp);
        endfunction

        function void note_request(t_req r);
            logic signed [DATA_W-1:0] removed;
            int n;
            case (r.cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    if (elems.size() >= CAPACITY) begin
                        add_expected('0, ST_FULL, '0, 1'b1);
                    end else begin
                        if (r.cmd == CMD_PUSH_FRONT) elems.push_front(r.value_in);
                        else elems.push_back(r.value_in);
                        add_expected('0, ST_OK, '0, 1'b1);
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK: begin
                    if (elems.size() == 0) begin
                        add_expected('0, ST_EMPTY, '0, 1'b1);
                    end else begin
                        if (r.cmd == CMD_POP_FRONT) removed = elems.pop_front();
                        else removed = elems.pop_back();
                        add_expected(removed, ST_OK, '0, 1'b1);
                    end
                end
                CMD_INSERT_AFTER: begin
                    if (r.position >= elems.size()) begin
                        add_expected('0, ST_NOPOS, '0, 1'b1);
                    end else if (elems.size() >= CAPACITY) begin
                        add_expected('0, ST_FULL, '0, 1'b1);
                    end else begin
                        elems.insert(int'(r.position) + 1, r.value_in);
                        add_expected('0, ST_OK, '0, 1'b1);
                    end
                end
                CMD_DELETE_AT: begin
                    if (r.position >= elems.size()) begin
                        add_expected('0, ST_NOPOS, '0, 1'b1);
                    end else begin
                        removed = elems[r.position];
                        elems.delete(r.position);
                        add_expected(removed, ST_OK, '0, 1'b1);
                    end
                end
                CMD_VIEW: begin
                    if (elems.size() == 0) begin
                        add_expected('0, ST_EMPTY, '0, 1'b1);
                    end else begin
                        n = (elems.size() < MAX_RESULTS) ? elems.size() : MAX_RESULTS;
                        for (int i = 0; i < n; i++)
                            add_expected(elems[i], ST_OK, ELEM_W'(i), i == n - 1);
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string field, logic signed [DATA_W-1:0] want,
                             logic signed [DATA_W-1:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected response, expected none, actual %0d/%0d/%0d/%0d",
                         $time, got.value_out, got.status, got.elem_pos, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.value_out !== want.value_out)
                report("value_out", want.value_out, got.value_out);
            if (got.status !== want.status)
                report("status", DATA_W'(want.status), DATA_W'(got.status));
            if (got.elem_pos !== want.elem_pos)
                report("elem_pos", DATA_W'(want.elem_pos), DATA_W'(got.elem_pos));
            if (got.last !== want.last)
                report("last", DATA_W'(want.last), DATA_W'(got.last));
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic i_rsp_stall = 1'b0;
    t_req i_req       = '0;
    logic o_req_stall;
    logic o_rsp_valid;
    t_rsp o_rsp;

    int req_gap_pct   = 0;
    int rsp_stall_pct = 0;
    int idle_cycles   = 0;

    list_scoreboard sb = new();

    bounded_ordered_list_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) sb.check_response(o_rsp);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic t_req make_req(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val,
                                      logic [POS_W-1:0] pos);
        t_req r;
        r.cmd      = cmd;
        r.value_in = val;
        r.position = pos;
        return r;
    endfunction

    function automatic t_req make_random_request(bit filling);
        int unsigned n;
        int unsigned roll;
        logic [CMD_W-1:0] cmd;
        logic signed [DATA_W-1:0] val;
        logic [POS_W-1:0] pos;
        n = sb.fill();
        roll = $urandom_range(0, 99);
        if (roll < 3) cmd = CMD_UNUSED;
        else if (roll < 10) cmd = CMD_VIEW;
        else if (roll < (filling ? 60 : 35))
            cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else if (roll < (filling ? 70 : 60))
            cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        else if (roll < (filling ? 88 : 80)) cmd = CMD_INSERT_AFTER;
        else cmd = CMD_DELETE_AT;
        val = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0: val = {1'b1, {(DATA_W-1){1'b0}}};
                1: val = {1'b0, {(DATA_W-1){1'b1}}};
                2: val = '0;
                default: val = '1;
            endcase
        end
        if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, n));
        else pos = POS_W'($urandom_range(0, 255));
        return make_req(cmd, val, pos);
    endfunction

    task automatic issue_request(input t_req r);
        while ($urandom_range(0, 99) < req_gap_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic wait_drained();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list corner cases
        issue_request(make_req(CMD_POP_FRONT, 32'sd5, 8'd0));
        issue_request(make_req(CMD_POP_BACK, 32'sd5, 8'd0));
        issue_request(make_req(CMD_VIEW, '0, 8'd0));
        issue_request(make_req(CMD_INSERT_AFTER, 32'sd7, 8'd0));
        issue_request(make_req(CMD_DELETE_AT, '0, 8'd0));
        issue_request(make_req(CMD_UNUSED, 32'sd1, 8'd1));
        // value extremes
        issue_request(make_req(CMD_PUSH_BACK, {1'b1, {(DATA_W-1){1'b0}}}, 8'd0));
        issue_request(make_req(CMD_PUSH_FRONT, {1'b0, {(DATA_W-1){1'b1}}}, 8'd0));
        issue_request(make_req(CMD_PUSH_BACK, '0, 8'd0));
        issue_request(make_req(CMD_PUSH_BACK, '1, 8'd0));
        issue_request(make_req(CMD_VIEW, '0, 8'd0));
        // insert after last appends, then positional edits
        issue_request(make_req(CMD_INSERT_AFTER, 32'sh5555_5555, 8'd3));
        issue_request(make_req(CMD_INSERT_AFTER, 32'shAAAA_AAAA, 8'd0));
        issue_request(make_req(CMD_INSERT_AFTER, 32'sd9, 8'd255));
        issue_request(make_req(CMD_DELETE_AT, '0, 8'd0));
        issue_request(make_req(CMD_DELETE_AT, '0, 8'd5));
        issue_request(make_req(CMD_DELETE_AT, '0, 8'd4));
        issue_request(make_req(CMD_DELETE_AT, '0, 8'd255));
        issue_request(make_req(CMD_VIEW, '0, 8'd0));
        issue_request(make_req(CMD_POP_BACK, '0, 8'd0));
        issue_request(make_req(CMD_POP_FRONT, '0, 8'd0));
        issue_request(make_req(CMD_VIEW, '0, 8'd0));
        issue_request(make_req(CMD_UNUSED, '1, 8'd255));
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    req_gap_pct   = 0;
                    rsp_stall_pct = 0;
                end
                1: begin
                    req_gap_pct   = 50;
                    rsp_stall_pct = 0;
                end
                2: begin
                    req_gap_pct   = 0;
                    rsp_stall_pct = 50;
                end
                default: begin
                    req_gap_pct   = 37;
                    rsp_stall_pct = 37;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
                issue_request(make_random_request((k % 40) < 20));
            wait_drained();
        end

        repeat (CAPACITY + 4) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bol_pkg.sv
rtl/bol_cell.sv
rtl/bounded_ordered_list_unit.sv
sim/bounded_ordered_list_unit_tb.sv
